[rtl/table_driven_fsm_engine_macros.svh]
// Assertion macros shared by the engine's RTL files.
// Depends on nothing; files that assert include it by name.
`ifndef TABLE_DRIVEN_FSM_ENGINE_MACROS_SVH
`define TABLE_DRIVEN_FSM_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define TFE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tfe: property violated");
`define TFE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tfe: property violated");
`else
`define TFE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TFE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/tfe_pkg.sv]
// Types and codes of the table driven state machine engine.
// Used by tfe_ovr and the top level of the engine; depends on nothing.
package tfe_pkg;

	localparam logic [3:0] OP_ADD_STATE  = 4'd0;
	localparam logic [3:0] OP_SET_START  = 4'd1;
	localparam logic [3:0] OP_ADD_SIMPLE = 4'd2;
	localparam logic [3:0] OP_ADD_RANGE  = 4'd3;
	localparam logic [3:0] OP_ADD_TIMED  = 4'd4;
	localparam logic [3:0] OP_OVERRIDE   = 4'd5;
	localparam logic [3:0] OP_VALIDATE   = 4'd6;
	localparam logic [3:0] OP_DISARM     = 4'd7;
	localparam logic [3:0] OP_RESET      = 4'd8;
	localparam logic [3:0] OP_MOVE       = 4'd9;
	localparam logic [3:0] OP_PULSE      = 4'd10;
	localparam logic [3:0] OP_TICK       = 4'd11;
	localparam logic [3:0] OP_FORCE      = 4'd12;

	localparam logic [1:0] KIND_SIMPLE = 2'd0;
	localparam logic [1:0] KIND_RANGE  = 2'd1;
	localparam logic [1:0] KIND_TIMED  = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam logic [1:0] CHK_OK          = 2'd0;
	localparam logic [1:0] CHK_BAD_START   = 2'd1;
	localparam logic [1:0] CHK_UNREACHABLE = 2'd2;
	localparam logic [1:0] CHK_OVERLAP     = 2'd3;

	localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

	typedef struct packed {
		logic [1:0]         kind;
		logic [7:0]         next;
		logic signed [15:0] low;
		logic signed [15:0] high;
		logic [15:0]        span;
	} slot_t;

	typedef struct packed {
		logic        wr;
		logic [7:0]  from_id;
		logic [7:0]  to_id;
		logic [15:0] dur;
	} ovr_req_t;

	typedef struct packed {
		logic        hit;
		logic        ok;
		logic [15:0] dur;
	} ovr_rsp_t;

endpackage

[rtl/tfe_cmd_if.sv]
// Command channel of the engine: one operation word with its operands.
// Depends on nothing.
interface tfe_cmd_if;
	logic               valid;
	logic               ready;
	logic [3:0]         op;
	logic [7:0]         first_state;
	logic [7:0]         second_state;
	logic signed [15:0] low_bound;
	logic signed [15:0] high_bound;
	logic signed [15:0] trigger_value;
	logic [15:0]        span_ticks;
	logic [1:0]         kind;

	modport source(output valid, op, first_state, second_state, low_bound, high_bound,
		trigger_value, span_ticks, kind, input ready);
	modport sink(input valid, op, first_state, second_state, low_bound, high_bound,
		trigger_value, span_ticks, kind, output ready);
endinterface

[rtl/tfe_res_if.sv]
// Result channel of the engine: one status word per command.
// Depends on nothing.
interface tfe_res_if;
	logic               valid;
	logic               ready;
	logic               ok;
	logic [1:0]         check_status;
	logic [7:0]         examined_state;
	logic [7:0]         present_state;
	logic [7:0]         previous_state;
	logic signed [15:0] taken_trigger;
	logic [1:0]         taken_kind;

	modport source(output valid, ok, check_status, examined_state, present_state,
		previous_state, taken_trigger, taken_kind, input ready);
	modport sink(input valid, ok, check_status, examined_state, present_state,
		previous_state, taken_trigger, taken_kind, output ready);
endinterface

[rtl/tfe_ram.sv]
// Generic single write port, single read port RAM with registered read.
// Depends on nothing.
module tfe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/tfe_ovr.sv]
// Timing override table: lookup by state pair, add, change and remove.
// Depends on tfe_pkg and the assertion macro header.
`include "table_driven_fsm_engine_macros.svh"
module tfe_ovr #(
	parameter int MAX_OVERRIDES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tfe_pkg::ovr_req_t req,
	output tfe_pkg::ovr_rsp_t rsp
);
	localparam int OIW = (MAX_OVERRIDES > 1) ? $clog2(MAX_OVERRIDES) : 1;
	localparam int OCW = $clog2(MAX_OVERRIDES + 1);

	logic [7:0]     from_q [MAX_OVERRIDES];
	logic [7:0]     to_q [MAX_OVERRIDES];
	logic [15:0]    dur_q [MAX_OVERRIDES];
	logic [OCW-1:0] cnt_q;
	logic           hit;
	logic [OIW-1:0] hidx;
	logic           room;

	always_comb begin
		hit  = 1'b0;
		hidx = '0;
		for (int i = 0; i < MAX_OVERRIDES; i++) begin
			if (!hit && OCW'(i) < cnt_q && from_q[i] == req.from_id && to_q[i] == req.to_id) begin
				hit  = 1'b1;
				hidx = OIW'(i);
			end
		end
	end

	assign room    = cnt_q < OCW'(MAX_OVERRIDES);
	assign rsp.hit = hit;
	assign rsp.ok  = hit || room;
	assign rsp.dur = dur_q[hidx];

	always_ff @(posedge clk) begin
		if (req.wr) begin
			if (hit) begin
				if (req.dur == '0) begin
					for (int i = 0; i < MAX_OVERRIDES - 1; i++) begin
						if (i >= int'(hidx) && OCW'(i + 1) < cnt_q) begin
							from_q[i] <= from_q[i + 1];
							to_q[i]   <= to_q[i + 1];
							dur_q[i]  <= dur_q[i + 1];
						end
					end
				end else begin
					dur_q[hidx] <= req.dur;
				end
			end else if (room) begin
				from_q[cnt_q[OIW-1:0]] <= req.from_id;
				to_q[cnt_q[OIW-1:0]]   <= req.to_id;
				dur_q[cnt_q[OIW-1:0]]  <= req.dur;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.wr) begin
			if (hit && req.dur == '0) begin
				cnt_q <= cnt_q - 1'b1;
			end else if (!hit && room) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	`TFE_ASSERT_IMP(a_ovr_cnt_max, clk, arst_n, 1'b1, cnt_q <= OCW'(MAX_OVERRIDES))
	`TFE_ASSERT_NXT(a_ovr_cnt_hold, clk, arst_n, !req.wr, $stable(cnt_q))
endmodule

[rtl/table_driven_fsm_engine.sv]
// Top level of the table driven state machine engine: sequencer over the
// transition RAM, state id table and machine registers.
// Depends on tfe_pkg, tfe_cmd_if, tfe_res_if, tfe_ram, tfe_ovr and the macro header.
//
//   channel  dir  handshake          contents
//   cmd      in   valid / ready      op and operands of one command
//   res      out  valid / ready      one status word per command
//
// One command at a time. Simple commands pass through S_EXEC and S_DONE; commands that
// walk transitions use a read state and a check state for each slot read from the
// transition RAM (move, pulse, tick and timed adds).
// Validate repeats reachability passes until no new state is marked, then scans
// range pairs per state.
// The next command is taken while a finished word waits on res.
// Reset clears all control state; the transition RAM needs no clearing.
`include "table_driven_fsm_engine_macros.svh"
module table_driven_fsm_engine #(
	parameter int MAX_STATES      = 16,
	parameter int MAX_TRANSITIONS = 8,
	parameter int MAX_OVERRIDES   = 16
) (
	input  logic   clk,
	input  logic   arst_n,
	tfe_cmd_if.sink   cmd,
	tfe_res_if.source res
);
	localparam int SIW   = $clog2(MAX_STATES);
	localparam int SCW   = $clog2(MAX_STATES + 1);
	localparam int TIW   = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
	localparam int TCW   = $clog2(MAX_TRANSITIONS + 1);
	localparam int DEPTH = MAX_STATES << TIW;
	localparam int AW    = SIW + TIW;
	localparam int SW    = $bits(tfe_pkg::slot_t);

	typedef enum logic [3:0] {
		S_IDLE, S_EXEC, S_TSCAN_RD, S_TSCAN_CK, S_MSCAN_RD, S_MSCAN_CK,
		S_BFS_RD, S_BFS_CK, S_UNREACH, S_OVL_A_RD, S_OVL_A_CK, S_OVL_B_RD,
		S_OVL_B_CK, S_DONE
	} state_t;

	state_t st_q;

	logic [3:0]         op_q;
	logic [7:0]         s1_q, s2_q;
	logic signed [15:0] lo_q, hi_q, trig_q;
	logic [15:0]        span_q;
	logic [1:0]         kind_q;

	logic [7:0]     ids_q [MAX_STATES];
	logic [SCW-1:0] scnt_q;
	logic [TCW-1:0] tcnt_q [MAX_STATES];
	logic [7:0]     start_q;
	logic           armed_q;
	logic [7:0]     cur_q, last_q;
	logic signed [15:0] ltrig_q;
	logic [1:0]     lkind_q;
	logic [15:0]    elap_q;
	logic [MAX_STATES-1:0] marks_q;

	logic [SCW-1:0] si_q;
	logic [TCW-1:0] sj_q, sk_q;
	logic           changed_q;
	tfe_pkg::slot_t a_q;

	logic       ok_q;
	logic [1:0] status_q;
	logic [7:0] culprit_q;

	logic               o_valid_q, o_ok_q;
	logic [1:0]         o_status_q, o_kind_q;
	logic [7:0]         o_culprit_q, o_cur_q, o_last_q;
	logic signed [15:0] o_trig_q;

	logic           accept;
	logic [SIW-1:0] si_idx;
	logic [TCW-1:0] tcnt_sel;
	logic [7:0]     k1;
	logic           h1, h2, h3;
	logic [SIW-1:0] i1, i2, i3;
	logic [TCW-1:0] tc1;
	logic           add_chk;
	logic           unr_found;
	logic [7:0]     unr_id;
	logic           ram_we;
	logic [AW-1:0]  ram_waddr, ram_raddr;
	logic [SW-1:0]  ram_rdata;
	tfe_pkg::slot_t rd, ent_new;
	tfe_pkg::ovr_req_t ovr_req;
	tfe_pkg::ovr_rsp_t ovr_rsp;
	logic [15:0]    dur_eff;
	logic           pulse_hit, ovl_hit, out_free;

	assign accept   = cmd.valid && cmd.ready;
	assign cmd.ready = (st_q == S_IDLE);
	assign si_idx   = si_q[SIW-1:0];
	assign tcnt_sel = tcnt_q[si_idx];
	assign rd       = tfe_pkg::slot_t'(ram_rdata);
	assign tc1      = tcnt_q[i1];
	assign add_chk  = !armed_q && h1 && h2;
	assign out_free = !o_valid_q || res.ready;

	always_comb begin
		if (op_q == tfe_pkg::OP_VALIDATE) begin
			k1 = start_q;
		end else if (op_q == tfe_pkg::OP_MOVE || op_q == tfe_pkg::OP_PULSE ||
				op_q == tfe_pkg::OP_TICK) begin
			k1 = cur_q;
		end else begin
			k1 = s1_q;
		end
	end

	always_comb begin
		h1 = 1'b0; h2 = 1'b0; h3 = 1'b0;
		i1 = '0;   i2 = '0;   i3 = '0;
		unr_found = 1'b0;
		unr_id    = '0;
		for (int i = 0; i < MAX_STATES; i++) begin
			if (SCW'(i) < scnt_q) begin
				if (!h1 && k1 != 8'd0 && ids_q[i] == k1) begin
					h1 = 1'b1; i1 = SIW'(i);
				end
				if (!h2 && s2_q != 8'd0 && ids_q[i] == s2_q) begin
					h2 = 1'b1; i2 = SIW'(i);
				end
				if (!h3 && rd.next != 8'd0 && ids_q[i] == rd.next) begin
					h3 = 1'b1; i3 = SIW'(i);
				end
				if (!unr_found && !marks_q[i]) begin
					unr_found = 1'b1; unr_id = ids_q[i];
				end
			end
		end
	end

	always_comb begin
		ent_new      = '0;
		ent_new.next = s2_q;
		case (op_q)
			tfe_pkg::OP_ADD_RANGE: begin
				ent_new.kind = tfe_pkg::KIND_RANGE;
				ent_new.low  = lo_q;
				ent_new.high = hi_q;
			end
			tfe_pkg::OP_ADD_TIMED: begin
				ent_new.kind = tfe_pkg::KIND_TIMED;
				ent_new.span = span_q;
			end
			default: ent_new.kind = tfe_pkg::KIND_SIMPLE;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = {si_idx, sj_q[TIW-1:0]};
		ram_raddr = {si_idx, sj_q[TIW-1:0]};
		case (st_q)
			S_EXEC: begin
				ram_we = (op_q == tfe_pkg::OP_ADD_SIMPLE || op_q == tfe_pkg::OP_ADD_RANGE) &&
					add_chk && tc1 < TCW'(MAX_TRANSITIONS);
				ram_waddr = {i1, tc1[TIW-1:0]};
			end
			S_TSCAN_RD: begin
				ram_we    = sj_q >= tcnt_sel && tcnt_sel < TCW'(MAX_TRANSITIONS);
				ram_waddr = {si_idx, tcnt_sel[TIW-1:0]};
			end
			S_TSCAN_CK: ram_we = (rd.kind == tfe_pkg::KIND_TIMED);
			S_OVL_B_RD: ram_raddr = {si_idx, sk_q[TIW-1:0]};
			default: ;
		endcase
	end

	always_comb begin
		ovr_req.wr  = (st_q == S_EXEC) && (op_q == tfe_pkg::OP_OVERRIDE);
		ovr_req.dur = span_q;
		if (st_q == S_MSCAN_CK) begin
			ovr_req.from_id = cur_q;
			ovr_req.to_id   = rd.next;
		end else begin
			ovr_req.from_id = s1_q;
			ovr_req.to_id   = s2_q;
		end
	end

	assign dur_eff   = (ovr_rsp.hit && ovr_rsp.dur != '0) ? ovr_rsp.dur : rd.span;
	assign pulse_hit = rd.kind == tfe_pkg::KIND_RANGE && $signed(rd.low) <= $signed(trig_q) &&
		$signed(trig_q) <= $signed(rd.high);
	assign ovl_hit   = rd.kind == tfe_pkg::KIND_RANGE && $signed(a_q.low) <= $signed(rd.high) &&
		$signed(rd.low) <= $signed(a_q.high);

	tfe_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ent_new),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	tfe_ovr #(.MAX_OVERRIDES(MAX_OVERRIDES)) u_ovr (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ovr_req),
		.rsp    (ovr_rsp)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= cmd.op;
			s1_q   <= cmd.first_state;
			s2_q   <= cmd.second_state;
			lo_q   <= cmd.low_bound;
			hi_q   <= cmd.high_bound;
			trig_q <= cmd.trigger_value;
			span_q <= cmd.span_ticks;
			kind_q <= cmd.kind;
		end
		if (st_q == S_EXEC && op_q == tfe_pkg::OP_ADD_STATE && !armed_q && s1_q != 8'd0 &&
				!h1 && scnt_q < SCW'(MAX_STATES)) begin
			ids_q[scnt_q[SIW-1:0]] <= s1_q;
		end
		if (st_q == S_OVL_A_CK) begin
			a_q <= rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			scnt_q      <= '0;
			for (int i = 0; i < MAX_STATES; i++) begin
				tcnt_q[i] <= '0;
			end
			start_q     <= '0;
			armed_q     <= 1'b0;
			cur_q       <= '0;
			last_q      <= '0;
			ltrig_q     <= '0;
			lkind_q     <= tfe_pkg::KIND_SIMPLE;
			elap_q      <= '0;
			marks_q     <= '0;
			si_q        <= '0;
			sj_q        <= '0;
			sk_q        <= '0;
			changed_q   <= 1'b0;
			ok_q        <= 1'b0;
			status_q    <= tfe_pkg::CHK_OK;
			culprit_q   <= '0;
			o_valid_q   <= 1'b0;
			o_ok_q      <= 1'b0;
			o_status_q  <= tfe_pkg::CHK_OK;
			o_culprit_q <= '0;
			o_cur_q     <= '0;
			o_last_q    <= '0;
			o_trig_q    <= '0;
			o_kind_q    <= tfe_pkg::KIND_SIMPLE;
		end else begin
			if (res.ready && st_q != S_DONE) begin
				o_valid_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (accept) begin
						ok_q      <= 1'b0;
						status_q  <= tfe_pkg::CHK_OK;
						culprit_q <= '0;
						st_q      <= S_EXEC;
					end
				end
				S_EXEC: begin
					st_q <= S_DONE;
					unique case (op_q) inside
						tfe_pkg::OP_ADD_STATE: begin
							if (!armed_q && s1_q != 8'd0 && !h1 && scnt_q < SCW'(MAX_STATES)) begin
								tcnt_q[scnt_q[SIW-1:0]] <= '0;
								scnt_q <= scnt_q + 1'b1;
								ok_q   <= 1'b1;
							end
						end
						tfe_pkg::OP_SET_START: begin
							if (!armed_q && h1) begin
								start_q <= s1_q;
								ok_q    <= 1'b1;
							end
						end
						tfe_pkg::OP_ADD_SIMPLE, tfe_pkg::OP_ADD_RANGE: begin
							if (add_chk && tc1 < TCW'(MAX_TRANSITIONS)) begin
								tcnt_q[i1] <= tc1 + 1'b1;
								ok_q       <= 1'b1;
							end
						end
						tfe_pkg::OP_ADD_TIMED: begin
							if (add_chk) begin
								si_q <= SCW'(i1);
								sj_q <= '0;
								st_q <= S_TSCAN_RD;
							end
						end
						tfe_pkg::OP_OVERRIDE: ok_q <= ovr_rsp.ok;
						tfe_pkg::OP_VALIDATE: begin
							if (!h1) begin
								status_q  <= tfe_pkg::CHK_BAD_START;
								culprit_q <= start_q;
							end else begin
								marks_q   <= MAX_STATES'(1) << i1;
								si_q      <= '0;
								sj_q      <= '0;
								changed_q <= 1'b0;
								st_q      <= S_BFS_RD;
							end
						end
						tfe_pkg::OP_DISARM: begin
							armed_q <= 1'b0;
							ok_q    <= 1'b1;
						end
						tfe_pkg::OP_RESET: begin
							if (armed_q) begin
								cur_q   <= start_q;
								last_q  <= start_q;
								ltrig_q <= '0;
								lkind_q <= tfe_pkg::KIND_SIMPLE;
								elap_q  <= '0;
								ok_q    <= 1'b1;
							end
						end
						tfe_pkg::OP_MOVE, tfe_pkg::OP_PULSE, tfe_pkg::OP_TICK: begin
							if (op_q == tfe_pkg::OP_TICK && elap_q != tfe_pkg::ELAPSED_MAX) begin
								elap_q <= elap_q + 1'b1;
							end
							if (armed_q && cur_q != 8'd0 && last_q != 8'd0 && h1) begin
								si_q <= SCW'(i1);
								sj_q <= '0;
								st_q <= S_MSCAN_RD;
							end
						end
						tfe_pkg::OP_FORCE: begin
							cur_q   <= s1_q;
							last_q  <= s2_q;
							ltrig_q <= trig_q;
							lkind_q <= (kind_q == tfe_pkg::KIND_UNUSED) ? tfe_pkg::KIND_SIMPLE : kind_q;
							elap_q  <= '0;
							ok_q    <= 1'b1;
						end
						default: ;
					endcase
				end
				S_TSCAN_RD: begin
					if (sj_q < tcnt_sel) begin
						st_q <= S_TSCAN_CK;
					end else begin
						if (tcnt_sel < TCW'(MAX_TRANSITIONS)) begin
							tcnt_q[si_idx] <= tcnt_sel + 1'b1;
							ok_q           <= 1'b1;
						end
						st_q <= S_DONE;
					end
				end
				S_TSCAN_CK: begin
					if (rd.kind == tfe_pkg::KIND_TIMED) begin
						ok_q <= 1'b1;
						st_q <= S_DONE;
					end else begin
						sj_q <= sj_q + 1'b1;
						st_q <= S_TSCAN_RD;
					end
				end
				S_MSCAN_RD: begin
					st_q <= (sj_q < tcnt_sel) ? S_MSCAN_CK : S_DONE;
				end
				S_MSCAN_CK: begin
					if (op_q == tfe_pkg::OP_MOVE && rd.next == s2_q) begin
						last_q  <= cur_q;
						cur_q   <= s2_q;
						lkind_q <= tfe_pkg::KIND_SIMPLE;
						ltrig_q <= '0;
						elap_q  <= '0;
						ok_q    <= 1'b1;
						st_q    <= S_DONE;
					end else if (op_q == tfe_pkg::OP_PULSE && pulse_hit) begin
						last_q  <= cur_q;
						cur_q   <= rd.next;
						lkind_q <= tfe_pkg::KIND_RANGE;
						ltrig_q <= trig_q;
						elap_q  <= '0;
						ok_q    <= 1'b1;
						st_q    <= S_DONE;
					end else if (op_q == tfe_pkg::OP_TICK && rd.kind == tfe_pkg::KIND_TIMED &&
							elap_q > dur_eff) begin
						last_q  <= cur_q;
						cur_q   <= rd.next;
						lkind_q <= tfe_pkg::KIND_TIMED;
						ltrig_q <= '0;
						elap_q  <= '0;
						ok_q    <= 1'b1;
						st_q    <= S_DONE;
					end else begin
						sj_q <= sj_q + 1'b1;
						st_q <= S_MSCAN_RD;
					end
				end
				S_BFS_RD: begin
					if (si_q >= scnt_q) begin
						si_q <= '0;
						sj_q <= '0;
						changed_q <= 1'b0;
						if (!changed_q) begin
							st_q <= S_UNREACH;
						end
					end else if (marks_q[si_idx] && sj_q < tcnt_sel) begin
						st_q <= S_BFS_CK;
					end else begin
						si_q <= si_q + 1'b1;
						sj_q <= '0;
					end
				end
				S_BFS_CK: begin
					if (h3) begin
						marks_q[i3] <= 1'b1;
						if (!marks_q[i3]) begin
							changed_q <= 1'b1;
						end
					end
					sj_q <= sj_q + 1'b1;
					st_q <= S_BFS_RD;
				end
				S_UNREACH: begin
					if (unr_found) begin
						status_q  <= tfe_pkg::CHK_UNREACHABLE;
						culprit_q <= unr_id;
						st_q      <= S_DONE;
					end else begin
						si_q <= '0;
						sj_q <= '0;
						st_q <= S_OVL_A_RD;
					end
				end
				S_OVL_A_RD: begin
					if (si_q >= scnt_q) begin
						armed_q <= 1'b1;
						ok_q    <= 1'b1;
						st_q    <= S_DONE;
					end else if (sj_q < tcnt_sel) begin
						st_q <= S_OVL_A_CK;
					end else begin
						si_q <= si_q + 1'b1;
						sj_q <= '0;
					end
				end
				S_OVL_A_CK: begin
					if (rd.kind == tfe_pkg::KIND_RANGE) begin
						sk_q <= sj_q + 1'b1;
						st_q <= S_OVL_B_RD;
					end else begin
						sj_q <= sj_q + 1'b1;
						st_q <= S_OVL_A_RD;
					end
				end
				S_OVL_B_RD: begin
					if (sk_q < tcnt_sel) begin
						st_q <= S_OVL_B_CK;
					end else begin
						sj_q <= sj_q + 1'b1;
						st_q <= S_OVL_A_RD;
					end
				end
				S_OVL_B_CK: begin
					if (ovl_hit) begin
						status_q  <= tfe_pkg::CHK_OVERLAP;
						culprit_q <= 8'(si_q);
						st_q      <= S_DONE;
					end else begin
						sk_q <= sk_q + 1'b1;
						st_q <= S_OVL_B_RD;
					end
				end
				S_DONE: begin
					if (out_free) begin
						o_valid_q   <= 1'b1;
						o_ok_q      <= ok_q;
						o_status_q  <= status_q;
						o_culprit_q <= culprit_q;
						o_cur_q     <= cur_q;
						o_last_q    <= last_q;
						o_trig_q    <= ltrig_q;
						o_kind_q    <= lkind_q;
						st_q        <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign res.valid          = o_valid_q;
	assign res.ok             = o_ok_q;
	assign res.check_status   = o_status_q;
	assign res.examined_state = o_culprit_q;
	assign res.present_state  = o_cur_q;
	assign res.previous_state = o_last_q;
	assign res.taken_trigger  = o_trig_q;
	assign res.taken_kind     = o_kind_q;

	`TFE_ASSERT_NXT(a_accept_exec, clk, arst_n, accept, st_q == S_EXEC)
	`TFE_ASSERT_NXT(a_arm_only_validate, clk, arst_n, !armed_q && st_q != S_OVL_A_RD, !armed_q)
	`TFE_ASSERT_IMP(a_scan_in_range, clk, arst_n, st_q == S_MSCAN_CK, sj_q < TCW'(MAX_TRANSITIONS))
	`TFE_ASSERT_IMP(a_state_cnt_max, clk, arst_n, 1'b1, scnt_q <= SCW'(MAX_STATES))
endmodule

[verif/tfe_tb_pkg.sv]
`timescale 1ns / 1ps
// Command word type shared by the engine testbench files.
// Depends on nothing.
package tfe_tb_pkg;
	typedef struct packed {
		logic [3:0]         op;
		logic [7:0]         first_state;
		logic [7:0]         second_state;
		logic signed [15:0] low_bound;
		logic signed [15:0] high_bound;
		logic signed [15:0] trigger_value;
		logic [15:0]        span_ticks;
		logic [1:0]         kind;
	} cmd_word_t;
endpackage

[verif/tfe_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the engine: watches both channels, predicts each result word
// and compares it field by field. Depends on tfe_pkg, tfe_tb_pkg and the channel interfaces.
module tfe_checker
	import tfe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	tfe_cmd_if          cmd,
	tfe_res_if          res,
	output int          fail_count,
	output int          pending_words,
	output int          ok_words
);
	localparam int NS = 16;
	localparam int NT = 8;
	localparam int NO = 16;

	typedef struct packed {
		logic       ok;
		logic [1:0] status;
		logic [7:0] culprit;
		logic [7:0] cur;
		logic [7:0] prev;
		logic [15:0] trig;
		logic [1:0] kind;
	} res_word_t;

	logic [7:0]  ids [NS];
	int          n_states;
	slot_t       slots [NS][NT];
	int          n_slots [NS];
	logic [7:0]  ov_from [NO];
	logic [7:0]  ov_to [NO];
	logic [15:0] ov_dur [NO];
	int          n_ovr;
	logic [7:0]  start_q, cur_q, prev_q;
	logic        armed_q;
	logic [15:0] trig_q, elapsed_q;
	logic [1:0]  kind_q;
	res_word_t   expected_words [$];

	function automatic int state_slot(logic [7:0] id);
		if (id == 0) return -1;
		for (int i = 0; i < n_states; i++) if (ids[i] == id) return i;
		return -1;
	endfunction

	function automatic int ovr_slot(logic [7:0] f, logic [7:0] t);
		for (int i = 0; i < n_ovr; i++) if (ov_from[i] == f && ov_to[i] == t) return i;
		return -1;
	endfunction

	function automatic logic add_edge(logic [7:0] f, logic [7:0] t, slot_t s);
		int fi, ti;
		if (armed_q) return 0;
		fi = state_slot(f);
		ti = state_slot(t);
		if (fi < 0 || ti < 0) return 0;
		if (s.kind == KIND_TIMED)
			for (int i = 0; i < n_slots[fi]; i++) if (slots[fi][i].kind == KIND_TIMED) begin
				slots[fi][i] = s;
				return 1;
			end
		if (n_slots[fi] >= NT) return 0;
		slots[fi][n_slots[fi]] = s;
		n_slots[fi]++;
		return 1;
	endfunction

	function automatic logic [1:0] check_graph(output logic [7:0] culprit);
		int si, t;
		logic [NS-1:0] marks;
		culprit = 0;
		si = state_slot(start_q);
		if (si < 0) begin
			culprit = start_q;
			return CHK_BAD_START;
		end
		marks = '0;
		marks[si] = 1;
		for (int p = 0; p < NS; p++)
			for (int i = 0; i < n_states; i++) if (marks[i])
				for (int j = 0; j < n_slots[i]; j++) begin
					t = state_slot(slots[i][j].next);
					if (t >= 0) marks[t] = 1;
				end
		for (int i = 0; i < n_states; i++) if (!marks[i]) begin
			culprit = ids[i];
			return CHK_UNREACHABLE;
		end
		for (int i = 0; i < n_states; i++)
			for (int j = 0; j < n_slots[i]; j++) if (slots[i][j].kind == KIND_RANGE)
				for (int k = j + 1; k < n_slots[i]; k++)
					if (slots[i][k].kind == KIND_RANGE && slots[i][j].low <= slots[i][k].high
							&& slots[i][k].low <= slots[i][j].high) begin
						culprit = i[7:0];
						return CHK_OVERLAP;
					end
		armed_q = 1;
		return CHK_OK;
	endfunction

	function automatic void take(logic [7:0] nxt, logic [1:0] k, logic [15:0] tr);
		prev_q = cur_q;
		cur_q = nxt;
		kind_q = k;
		trig_q = tr;
		elapsed_q = 0;
	endfunction

	function automatic res_word_t engine_step(tfe_tb_pkg::cmd_word_t c);
		res_word_t r;
		slot_t s;
		int ci, oi;
		logic [15:0] dur;
		r = '0;
		s = '0;
		s.next = c.second_state;
		case (c.op)
			OP_ADD_STATE: if (!armed_q && c.first_state != 0 && state_slot(c.first_state) < 0
					&& n_states < NS) begin
				ids[n_states] = c.first_state;
				n_slots[n_states] = 0;
				n_states++;
				r.ok = 1;
			end
			OP_SET_START: if (!armed_q && state_slot(c.first_state) >= 0) begin
				start_q = c.first_state;
				r.ok = 1;
			end
			OP_ADD_SIMPLE: begin
				s.kind = KIND_SIMPLE;
				r.ok = add_edge(c.first_state, c.second_state, s);
			end
			OP_ADD_RANGE: begin
				s.kind = KIND_RANGE;
				s.low = c.low_bound;
				s.high = c.high_bound;
				r.ok = add_edge(c.first_state, c.second_state, s);
			end
			OP_ADD_TIMED: begin
				s.kind = KIND_TIMED;
				s.span = c.span_ticks;
				r.ok = add_edge(c.first_state, c.second_state, s);
			end
			OP_OVERRIDE: begin
				oi = ovr_slot(c.first_state, c.second_state);
				if (oi >= 0) begin
					if (c.span_ticks == 0) begin
						for (int i = oi; i + 1 < n_ovr; i++) begin
							ov_from[i] = ov_from[i+1];
							ov_to[i] = ov_to[i+1];
							ov_dur[i] = ov_dur[i+1];
						end
						n_ovr--;
					end else ov_dur[oi] = c.span_ticks;
					r.ok = 1;
				end else if (n_ovr < NO) begin
					ov_from[n_ovr] = c.first_state;
					ov_to[n_ovr] = c.second_state;
					ov_dur[n_ovr] = c.span_ticks;
					n_ovr++;
					r.ok = 1;
				end
			end
			OP_VALIDATE: begin
				r.status = check_graph(r.culprit);
				r.ok = (r.status == CHK_OK);
			end
			OP_DISARM: begin
				armed_q = 0;
				r.ok = 1;
			end
			OP_RESET: if (armed_q) begin
				cur_q = start_q;
				prev_q = start_q;
				trig_q = 0;
				kind_q = KIND_SIMPLE;
				elapsed_q = 0;
				r.ok = 1;
			end
			OP_MOVE, OP_PULSE, OP_TICK: begin
				if (c.op == OP_TICK && elapsed_q != ELAPSED_MAX) elapsed_q++;
				ci = state_slot(cur_q);
				if (armed_q && cur_q != 0 && prev_q != 0 && ci >= 0)
					for (int i = 0; i < n_slots[ci]; i++) begin
						if (c.op == OP_MOVE) begin
							if (slots[ci][i].next == c.second_state) begin
								take(c.second_state, KIND_SIMPLE, 0);
								r.ok = 1;
								break;
							end
						end else if (c.op == OP_PULSE) begin
							if (slots[ci][i].kind == KIND_RANGE
									&& slots[ci][i].low <= c.trigger_value
									&& c.trigger_value <= slots[ci][i].high) begin
								take(slots[ci][i].next, KIND_RANGE, c.trigger_value);
								r.ok = 1;
								break;
							end
						end else if (slots[ci][i].kind == KIND_TIMED) begin
							dur = slots[ci][i].span;
							oi = ovr_slot(cur_q, slots[ci][i].next);
							if (oi >= 0 && ov_dur[oi] != 0) dur = ov_dur[oi];
							if (elapsed_q > dur) begin
								take(slots[ci][i].next, KIND_TIMED, 0);
								r.ok = 1;
								break;
							end
						end
					end
			end
			OP_FORCE: begin
				cur_q = c.first_state;
				prev_q = c.second_state;
				trig_q = c.trigger_value;
				kind_q = (c.kind == KIND_UNUSED) ? KIND_SIMPLE : c.kind;
				elapsed_q = 0;
				r.ok = 1;
			end
			default: ;
		endcase
		r.cur = cur_q;
		r.prev = prev_q;
		r.trig = trig_q;
		r.kind = kind_q;
		return r;
	endfunction

	task automatic compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	assign pending_words = expected_words.size();

	always @(posedge clk or negedge arst_n) begin
		tfe_tb_pkg::cmd_word_t c;
		res_word_t want;
		if (!arst_n) begin
			n_states = 0;
			n_ovr = 0;
			for (int i = 0; i < NS; i++) n_slots[i] = 0;
			start_q = 0;
			cur_q = 0;
			prev_q = 0;
			armed_q = 0;
			trig_q = 0;
			kind_q = KIND_SIMPLE;
			elapsed_q = 0;
			fail_count = 0;
			ok_words = 0;
			expected_words.delete();
		end else begin
			if (cmd.valid && cmd.ready) begin
				c = {cmd.op, cmd.first_state, cmd.second_state, cmd.low_bound, cmd.high_bound,
					cmd.trigger_value, cmd.span_ticks, cmd.kind};
				expected_words.push_back(engine_step(c));
			end
			if (res.valid && res.ready) begin
				if (expected_words.size() == 0) begin
					$error("result word with nothing expected");
					fail_count++;
				end else begin
					want = expected_words.pop_front();
					if (want.ok) ok_words++;
					compare_field("ok", want.ok, res.ok);
					compare_field("check_status", want.status, res.check_status);
					compare_field("examined_state", want.culprit, res.examined_state);
					compare_field("present_state", want.cur, res.present_state);
					compare_field("previous_state", want.prev, res.previous_state);
					compare_field("taken_trigger", want.trig, $unsigned(res.taken_trigger));
					compare_field("taken_kind", want.kind, res.taken_kind);
				end
			end
		end
	end
endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// Testbench top for the engine: builds machines, runs them under random idling and reports
// the verdict. Depends on tfe_pkg, tfe_tb_pkg, the interfaces, tfe_checker and the engine.
module tb;
	import tfe_pkg::*;
	import tfe_tb_pkg::*;

	localparam int WATCHDOG = 20000;

	logic clk = 0;
	logic arst_n = 0;
	int   fail_count, pending_words, ok_words;
	int   send_idle, recv_stall;
	int   quiet_cycles;
	int   words_sent;
	logic [7:0] pool [6];

	tfe_cmd_if cmd();
	tfe_res_if res();

	table_driven_fsm_engine dut (.clk(clk), .arst_n(arst_n), .cmd(cmd), .res(res));
	tfe_checker checker_i (.clk(clk), .arst_n(arst_n), .cmd(cmd), .res(res),
		.fail_count(fail_count), .pending_words(pending_words), .ok_words(ok_words));

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	always @(posedge clk) begin
		if (!arst_n) res.ready <= 0;
		else res.ready <= ($urandom_range(99) >= recv_stall);
	end

	always @(posedge clk) begin
		if ((cmd.valid && cmd.ready) || (res.valid && res.ready)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= WATCHDOG) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send(logic [3:0] op, logic [7:0] a, logic [7:0] b,
			logic [15:0] lo = 0, logic [15:0] hi = 0, logic [15:0] tr = 0,
			logic [15:0] sp = 0, logic [1:0] k = 0);
		while ($urandom_range(99) < send_idle) begin
			cmd.valid <= 0;
			@(posedge clk);
		end
		cmd.valid <= 1;
		cmd.op <= op;
		cmd.first_state <= a;
		cmd.second_state <= b;
		cmd.low_bound <= lo;
		cmd.high_bound <= hi;
		cmd.trigger_value <= tr;
		cmd.span_ticks <= sp;
		cmd.kind <= k;
		do @(posedge clk); while (!cmd.ready);
		words_sent++;
	endtask

	task automatic drain();
		cmd.valid <= 0;
		while (pending_words != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_id();
		return ($urandom_range(9) == 0) ? 8'($urandom) : pool[$urandom_range(5)];
	endfunction

	function automatic logic [15:0] rnd16();
		case ($urandom_range(3))
			0: return 16'h8000;
			1: return 16'h7FFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic build_machine();
		logic [15:0] lo;
		for (int i = 0; i < 6; i++) pool[i] = 8'($urandom_range(255, 1));
		send(OP_DISARM, 0, 0);
		for (int i = 0; i < 6; i++) send(OP_ADD_STATE, pool[i], 0);
		send(OP_SET_START, pool[0], 0);
		for (int i = 0; i < 6; i++) send(OP_ADD_SIMPLE, pool[i], pool[(i + 1) % 6]);
		for (int i = 0; i < 4; i++) begin
			lo = 16'($urandom_range(8) * 4000 - 16000);
			send(OP_ADD_RANGE, pool[$urandom_range(5)], pick_id(), lo,
				lo + 16'($urandom_range(4000)));
		end
		for (int i = 0; i < 3; i++)
			send(OP_ADD_TIMED, pick_id(), pick_id(), 0, 0, 0, 16'($urandom_range(6)));
		send(OP_VALIDATE, 0, 0);
	endtask

	task automatic random_op();
		case ($urandom_range(19))
			0, 1, 2, 3: send(OP_MOVE, 0, pick_id());
			4, 5, 6, 7: send(OP_PULSE, 0, 0, 0, 0, rnd16());
			8, 9, 10, 11, 12: send(OP_TICK, 0, 0);
			13: send(OP_RESET, 0, 0);
			14: send(OP_FORCE, pick_id(), pick_id(), 0, 0, rnd16(), 0, 2'($urandom));
			15: send(OP_OVERRIDE, pick_id(), pick_id(), 0, 0, 0,
				($urandom_range(2) == 0) ? 16'd0 : 16'($urandom_range(5)));
			16: send(OP_VALIDATE, 0, 0);
			17: send(OP_ADD_STATE, pick_id(), 0);
			18: send(4'($urandom_range(15, 13)), 8'($urandom), 8'($urandom), rnd16(), rnd16());
			default: send(4'($urandom_range(4)), pick_id(), pick_id(), rnd16(), rnd16(),
				rnd16(), 16'($urandom), 2'($urandom));
		endcase
	endtask

	initial begin
		cmd.valid = 0;
		cmd.op = 0;
		cmd.first_state = 0;
		cmd.second_state = 0;
		cmd.low_bound = 0;
		cmd.high_bound = 0;
		cmd.trigger_value = 0;
		cmd.span_ticks = 0;
		cmd.kind = 0;
		send_idle = 0;
		recv_stall = 0;
		words_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: ops before arming, bad ids, validation failures, forcing, timed adds, overrides.
		send(OP_TICK, 0, 0);
		send(OP_MOVE, 0, 1);
		send(OP_ADD_STATE, 0, 0);
		send(OP_ADD_STATE, 8'hFF, 0);
		send(OP_ADD_STATE, 8'hFF, 0);
		send(OP_ADD_STATE, 8'h01, 0);
		send(OP_SET_START, 0, 0);
		send(OP_VALIDATE, 0, 0);
		send(OP_SET_START, 8'hFF, 0);
		send(OP_VALIDATE, 0, 0);
		send(OP_ADD_SIMPLE, 8'hFF, 8'h01);
		send(OP_ADD_SIMPLE, 8'hFF, 8'h07);
		send(OP_ADD_RANGE, 8'h01, 8'hFF, 16'h8000, 16'h0000);
		send(OP_ADD_RANGE, 8'h01, 8'h01, 16'h0000, 16'h7FFF);
		send(OP_VALIDATE, 0, 0);
		send(OP_FORCE, 8'hFF, 8'h01, 16'h0, 16'h0, 16'h8000, 16'h0, KIND_UNUSED);
		send(OP_FORCE, 8'hAA, 8'h55, 16'h0, 16'h0, 16'h7FFF, 16'hFFFF, KIND_TIMED);
		send(OP_ADD_TIMED, 8'h01, 8'hFF, 0, 0, 0, 16'hFFFF);
		send(OP_ADD_TIMED, 8'h01, 8'hFF, 0, 0, 0, 16'd0);
		send(OP_OVERRIDE, 8'h01, 8'hFF, 0, 0, 0, 16'd0);
		send(OP_OVERRIDE, 8'h01, 8'hFF, 0, 0, 0, 16'hFFFF);
		send(OP_DISARM, 0, 0);
		send(4'd15, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 65; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 65; end
				default: begin send_idle = 12; recv_stall = 12; end
			endcase
			for (int m = 0; m < 2; m++) begin
				build_machine();
				send(OP_RESET, 0, 0);
				for (int i = 0; i < 45; i++) random_op();
			end
			drain();
			// Let the result channel empty before the idling pattern changes.
		end

		$display("Sent %0d command words over four idling phases; %0d results reported ok.",
			words_sent, ok_words);
		if (fail_count == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end
endmodule
